@@ hdl/prq_pkg.sv @@
// Package for the priority ready-queue scheduler.
// Holds opcodes, status codes, controller states and the command and status structs.
`timescale 1ns / 1ps

package prq_pkg;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_YIELD  = 2'd1;
    localparam logic [1:0] OP_TERM   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic push;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_push;
    } t_stat;

endpackage

@@ hdl/prq_if.sv @@
// Handshake channels of the priority ready-queue scheduler.
// Depends on nothing; used by the top level and its users.
`timescale 1ns / 1ps

interface prq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] create_id;
    logic [7:0] priority_req;

    modport source (output valid, output opcode, output create_id, output priority_req,
                    input ready);
    modport sink (input valid, input opcode, input create_id, input priority_req,
                  output ready);
endinterface

interface prq_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] running_id;
    logic       running_valid;
    logic [1:0] status;
    logic [4:0] ready_count;

    modport source (output valid, output running_id, output running_valid, output status,
                    output ready_count, input ready);
    modport sink (input valid, input running_id, input running_valid, input status,
                  input ready_count, output ready);
endinterface

@@ hdl/prq_ctrl.sv @@
// Controller of the priority ready-queue scheduler: sequences each item.
// Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_ctrl
    import prq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.need_push ? S_PUSH : S_RESP;
            end
            S_PUSH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) n_state = i_in_valid ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE) || ((r_state == S_RESP) && w_out_free);
        o_cmd.latch    = i_in_valid && o_in_ready;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.push     = (r_state == S_PUSH);
        o_cmd.load_out = (r_state == S_RESP) && w_out_free;
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/prq_dp.sv @@
// Datapath of the priority ready-queue scheduler: sorted cell row, running thread, result.
// Depends on prq_pkg.
`timescale 1ns / 1ps

module prq_dp
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_create_id,
    input  logic [7:0] i_priority_req,
    output t_stat      o_stat,
    output logic [7:0] o_running_id,
    output logic       o_running_valid,
    output logic [1:0] o_status,
    output logic [4:0] o_ready_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Cell row, slot 0 is the head; slots at or above the count are don't-care.
    logic [7:0]       r_ids [QUEUE_DEPTH];
    logic [7:0]       r_pri [QUEUE_DEPTH];
    logic [7:0]       n_ids [QUEUE_DEPTH];
    logic [7:0]       n_pri [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;

    logic [7:0] r_cur_id, n_cur_id;
    logic [7:0] r_cur_pri, n_cur_pri;
    logic       r_cur_valid, n_cur_valid;
    logic [7:0] r_hold_id, r_hold_pri;

    logic [1:0] r_op;
    logic [7:0] r_tid, r_tpri;
    logic [1:0] r_status, n_status;

    logic [7:0] r_out_id;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [4:0] r_out_count;

    logic             w_empty, w_full;
    logic             w_ins, w_pop;
    logic [7:0]       w_ins_id, w_ins_pri;
    logic [QUEUE_DEPTH-1:0] w_after;
    logic [QUEUE_DEPTH-1:0] w_prev;
    logic [CNT_W+4:0] w_cnt_ext;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_ins_id  = i_cmd.push ? r_hold_id : r_tid;
    assign w_ins_pri = i_cmd.push ? r_hold_pri : r_tpri;

    assign o_stat.need_push = (r_op == OP_YIELD) && !w_empty && r_cur_valid;

    always_comb begin
        w_ins       = 1'b0;
        w_pop       = 1'b0;
        n_count     = r_count;
        n_cur_id    = r_cur_id;
        n_cur_pri   = r_cur_pri;
        n_cur_valid = r_cur_valid;
        n_status    = r_status;
        if (i_cmd.exec) begin
            n_status = STAT_OK;
            case (r_op)
                OP_CREATE: begin
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_ins   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_YIELD: begin
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        w_pop       = 1'b1;
                        n_count     = r_count - 1'b1;
                        n_cur_id    = r_ids[0];
                        n_cur_pri   = r_pri[0];
                        n_cur_valid = 1'b1;
                    end
                end
                OP_TERM: begin
                    if (w_empty) begin
                        n_cur_id    = 8'd0;
                        n_cur_pri   = 8'd0;
                        n_cur_valid = 1'b0;
                    end else begin
                        w_pop       = 1'b1;
                        n_count     = r_count - 1'b1;
                        n_cur_id    = r_ids[0];
                        n_cur_pri   = r_pri[0];
                        n_cur_valid = 1'b1;
                    end
                end
                default: begin
                    n_status = STAT_OK;
                end
            endcase
        end else if (i_cmd.push) begin
            w_ins   = 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    // A new entry goes behind every occupied cell of equal or lower number.
    assign w_prev = {w_after[QUEUE_DEPTH-2:0], 1'b1};

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        assign w_after[k] = (CNT_W'(k) < r_count) && (r_pri[k] <= w_ins_pri);

        always_comb begin
            n_ids[k] = r_ids[k];
            n_pri[k] = r_pri[k];
            if (w_ins && !w_after[k]) begin
                if (w_prev[k]) begin
                    n_ids[k] = w_ins_id;
                    n_pri[k] = w_ins_pri;
                end else begin
                    if (k > 0) begin
                        n_ids[k] = r_ids[(k > 0) ? k - 1 : 0];
                        n_pri[k] = r_pri[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (w_pop) begin
                if (k < QUEUE_DEPTH - 1) begin
                    n_ids[k] = r_ids[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
                    n_pri[k] = r_pri[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_ids[k] <= n_ids[k];
            r_pri[k] <= n_pri[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur_id    <= 8'd0;
            r_cur_pri   <= 8'd1;
            r_cur_valid <= 1'b1;
        end else begin
            r_count     <= n_count;
            r_cur_id    <= n_cur_id;
            r_cur_pri   <= n_cur_pri;
            r_cur_valid <= n_cur_valid;
        end
    end

    assign w_cnt_ext = {5'd0, r_count};

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_tid  <= i_create_id;
            r_tpri <= i_priority_req;
        end
        // The thread that yields waits here until the row can take it back.
        if (i_cmd.exec) begin
            r_hold_id  <= r_cur_id;
            r_hold_pri <= r_cur_pri;
        end
        if (i_cmd.load_out) begin
            r_out_id     <= r_cur_valid ? r_cur_id : 8'd0;
            r_out_valid  <= r_cur_valid;
            r_out_status <= r_status;
            r_out_count  <= w_cnt_ext[4:0];
        end
    end

    assign o_running_id    = r_out_id;
    assign o_running_valid = r_out_valid;
    assign o_status        = r_out_status;
    assign o_ready_count   = r_out_count;

endmodule

@@ hdl/priority_ready_queue_scheduler.sv @@
// Priority ready-queue thread scheduler.
//
// Request channel i_req carries an opcode (create, yield, terminate), a thread id and
// a priority; a lower priority number is served first and equal numbers queue in
// arrival order. Response channel o_rsp returns one item per request: the running
// thread, whether one runs, a status code and the number of waiting entries.
// A request is taken on an edge where valid and ready are both high. The block then
// executes it, puts a running thread that yields back into the queue if one runs and
// the queue was not empty, and loads the response. One request is in work at a time;
// a new one is taken in the cycle the previous response is loaded, once the output
// register is free. The pace is set by the single insert port of the
// sorted cell row, which moves every entry by at most one place per cycle.
// The response sits in an output register; while it is not taken, the block finishes
// the next request and then holds it without taking another.
// Reset (synchronous, active low) empties the queue and makes thread 0 run with
// priority 1; queue contents need no clearing.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    prq_req_if.sink        i_req,
    prq_rsp_if.source      o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    prq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_req.opcode),
        .i_create_id     (i_req.create_id),
        .i_priority_req  (i_req.priority_req),
        .o_stat          (w_stat),
        .o_running_id    (o_rsp.running_id),
        .o_running_valid (o_rsp.running_valid),
        .o_status        (o_rsp.status),
        .o_ready_count   (o_rsp.ready_count)
    );

`ifndef SYNTHESIS
    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_cmd.exec)
        else $error("accepted item was not executed in the next cycle");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_rsp.valid)
        else $error("loaded result is not presented");

    a_steps_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.exec, w_cmd.push, w_cmd.load_out}))
        else $error("more than one controller step in a cycle");

    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.running_valid) |-> (o_rsp.running_id == 8'd0))
        else $error("running id not zero while no thread runs");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((QUEUE_DEPTH > 31) || (32'(o_rsp.ready_count) <= QUEUE_DEPTH)))
        else $error("ready count above queue depth");
`endif

endmodule

@@ bench/priority_ready_queue_scheduler_tb.sv @@
// Self-checking testbench for the priority ready-queue thread scheduler.
// Depends on prq_pkg, the prq_req_if and prq_rsp_if channels and the scheduler top level.
// A directed table runs first, then random phases; every response is checked against a typed or predicted value.
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_tb
    import prq_pkg::*;
();

    localparam int QDEPTH       = 16;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int SETTLE_TICKS = 10;

    // The fourth opcode value is a plain status read.
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [7:0] running_id;
        logic       running_valid;
        logic [1:0] status;
        logic [4:0] ready_count;
    } t_sched_rsp;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tid;
        logic [7:0] pri;
        logic       has_rsp;
        t_sched_rsp rsp;
    } t_stim_row;

    localparam t_sched_rsp NO_RSP = '0;

    // Rows with a typed response are easy to read off by hand; the rest use the predictor.
    t_stim_row directed_rows [0:21] = '{
        '{OP_YIELD,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, STAT_EMPTY, 5'd0}},
        '{OP_NOP,    8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b1, STAT_OK,    5'd0}},
        '{OP_CREATE, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b1, STAT_OK,    5'd1}},
        '{OP_CREATE, 8'h3C, 8'h00, 1'b1, '{8'h00, 1'b1, STAT_OK,    5'd2}},
        '{OP_CREATE, 8'hA5, 8'h00, 1'b1, '{8'h00, 1'b1, STAT_OK,    5'd3}},
        '{OP_YIELD,  8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_YIELD,  8'hFF, 8'hFF, 1'b0, NO_RSP},
        '{OP_TERM,   8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_TERM,   8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_TERM,   8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_TERM,   8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b0, STAT_OK,    5'd0}},
        '{OP_YIELD,  8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_EMPTY, 5'd0}},
        '{OP_TERM,   8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, STAT_OK,    5'd0}},
        '{OP_CREATE, 8'h81, 8'h7F, 1'b1, '{8'h00, 1'b0, STAT_OK,    5'd1}},
        '{OP_CREATE, 8'h7E, 8'h80, 1'b0, NO_RSP},
        '{OP_YIELD,  8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_YIELD,  8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_CREATE, 8'h55, 8'h7F, 1'b0, NO_RSP},
        '{OP_TERM,   8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_NOP,    8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_TERM,   8'h00, 8'h00, 1'b0, NO_RSP},
        '{OP_CREATE, 8'h01, 8'h01, 1'b0, NO_RSP}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    prq_req_if req_if ();
    prq_rsp_if rsp_if ();

    priority_ready_queue_scheduler #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted scheduler state.
    logic [7:0] rq_id  [QDEPTH];
    logic [7:0] rq_pri [QDEPTH];
    int         rq_cnt    = 0;
    logic [7:0] run_id    = 8'h00;
    logic [7:0] run_pri   = 8'h01;
    logic       run_valid = 1'b1;

    t_sched_rsp awaited_rsp [$];
    t_sched_rsp oldest_rsp;
    int         errors      = 0;
    int         cycles      = 0;
    bit         calm        = 1'b0;
    bit         rsp_hold_go = 1'b0;
    int         hold_left   = 0;

    // A new entry goes behind every entry of equal or lower number.
    function automatic void rq_insert(input logic [7:0] id, input logic [7:0] pri);
        int pos = 0;
        while (pos < rq_cnt && rq_pri[pos] <= pri)
            pos++;
        for (int k = rq_cnt; k > pos; k--) begin
            rq_id[k]  = rq_id[k-1];
            rq_pri[k] = rq_pri[k-1];
        end
        rq_id[pos]  = id;
        rq_pri[pos] = pri;
        rq_cnt++;
    endfunction

    function automatic void rq_pop(output logic [7:0] id, output logic [7:0] pri);
        id  = rq_id[0];
        pri = rq_pri[0];
        for (int k = 1; k < rq_cnt; k++) begin
            rq_id[k-1]  = rq_id[k];
            rq_pri[k-1] = rq_pri[k];
        end
        rq_cnt--;
    endfunction

    function automatic t_sched_rsp next_schedule(input logic [1:0] op, input logic [7:0] tid,
                                                 input logic [7:0] pri);
        logic [1:0] st = STAT_OK;
        logic [7:0] head_id;
        logic [7:0] head_pri;
        case (op)
            OP_CREATE: begin
                if (rq_cnt >= QDEPTH)
                    st = STAT_FULL;
                else
                    rq_insert(tid, pri);
            end
            OP_YIELD: begin
                if (rq_cnt == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    rq_pop(head_id, head_pri);
                    if (run_valid)
                        rq_insert(run_id, run_pri);
                    run_id    = head_id;
                    run_pri   = head_pri;
                    run_valid = 1'b1;
                end
            end
            OP_TERM: begin
                if (rq_cnt == 0) begin
                    run_valid = 1'b0;
                    run_id    = 8'h00;
                    run_pri   = 8'h00;
                end else begin
                    rq_pop(head_id, head_pri);
                    run_id    = head_id;
                    run_pri   = head_pri;
                    run_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return '{run_valid ? run_id : 8'h00, run_valid, st, rq_cnt[4:0]};
    endfunction

    // Offers one item, with a random gap before it unless idling is switched off.
    task automatic offer(input logic [1:0] op, input logic [7:0] tid, input logic [7:0] pri,
                         input logic has_rsp, input t_sched_rsp typed_rsp);
        t_sched_rsp pred;
        while (!calm && $urandom_range(0, 99) < 11) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        = 1'b1;
        req_if.opcode       = op;
        req_if.create_id    = tid;
        req_if.priority_req = pri;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        pred = next_schedule(op, tid, pri);
        awaited_rsp.push_back(has_rsp ? typed_rsp : pred);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (awaited_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    // Weights are out of a hundred; terminate takes what is left after a few status reads.
    task automatic run_phase(input int n, input int w_create, input int w_yield,
                             input int pri_max);
        int         r;
        logic [1:0] op;
        logic [7:0] pri;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_NOP;
            else if (r < 3 + w_create)
                op = OP_CREATE;
            else if (r < 3 + w_create + w_yield)
                op = OP_YIELD;
            else
                op = OP_TERM;
            r = $urandom_range(0, 99);
            if (r < 5)
                pri = 8'h00;
            else if (r < 10)
                pri = 8'hFF;
            else
                pri = 8'($urandom_range(0, pri_max));
            offer(op, 8'($urandom_range(0, 255)), pri, 1'b0, NO_RSP);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver: random stalls, or one long hold-off counted here when asked for.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
        end else if (rsp_hold_go) begin
            rsp_if.ready = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_hold_go  = 1'b0;
        end else begin
            rsp_if.ready = calm || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_rsp.size() == 0) begin
                $display("%0t: response with none awaited, actual %0h/%0b/%0h/%0d", $time,
                         rsp_if.running_id, rsp_if.running_valid, rsp_if.status,
                         rsp_if.ready_count);
                errors++;
            end else begin
                oldest_rsp = awaited_rsp.pop_front();
                check_field("running_id", oldest_rsp.running_id, rsp_if.running_id);
                check_field("running_valid", oldest_rsp.running_valid, rsp_if.running_valid);
                check_field("status", oldest_rsp.status, rsp_if.status);
                check_field("ready_count", oldest_rsp.ready_count, rsp_if.ready_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("priority_ready_queue_scheduler_tb NOT OK");
            $finish;
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.opcode       = OP_CREATE;
        req_if.create_id    = 8'h00;
        req_if.priority_req = 8'h00;
        rsp_if.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].op, directed_rows[i].tid, directed_rows[i].pri,
                  directed_rows[i].has_rsp, directed_rows[i].rsp);
        wait_drained();

        // Fill the queue well past full, then churn with many equal priorities.
        run_phase(80, 80, 10, 255);
        wait_drained();
        run_phase(80, 30, 50, 3);
        wait_drained();

        calm = 1'b1;
        run_phase(80, 40, 40, 255);
        wait_drained();
        calm = 1'b0;

        // The receiver stops for a long while and the block backs up into the request side.
        rsp_hold_go = 1'b1;
        run_phase(60, 60, 20, 15);
        wait_drained();

        // Mostly terminates, so the queue empties and no thread is left running.
        run_phase(80, 15, 25, 255);
        wait_drained();
        run_phase(100, 40, 30, 255);
        wait_drained();
        run_phase(80, 35, 45, 1);
        wait_drained();
        run_phase(60, 45, 25, 255);
        wait_drained();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (awaited_rsp.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, awaited_rsp.size());
            errors++;
        end
        if (errors == 0)
            $display("priority_ready_queue_scheduler_tb OK");
        else
            $display("priority_ready_queue_scheduler_tb NOT OK");
        $finish;
    end

endmodule
